@@ rtl/nsc_pkg.sv @@
// Shared widths, codes, states and control types of the nearest seed classifier.
`default_nettype none

package nsc_pkg;

  localparam int MODE_W       = 1;
  localparam int SEED_INDEX_W = 6;
  localparam int POS_W        = 10;
  localparam int LABEL_W      = 3;
  localparam int DIST_W       = 21;
  localparam int COUNT_W      = 7;
  // Widest coordinate the design supports; inputs are extended to this first.
  localparam int COORD_EXT_W  = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_WRITE = 1'b0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } nsc_state_e;

  typedef struct packed {
    logic start;     // latch query point, reset running best
    logic wr_en;     // store the seed carried by the accepted transaction
    logic issue;     // read one table entry into the distance pipeline
    logic load_out;  // copy the running best into the result register
  } nsc_cmd_t;

endpackage : nsc_pkg

`default_nettype wire

@@ rtl/nsc_item_if.sv @@
// Input channel interface: seed writes and grid point queries.
`default_nettype none

interface nsc_item_if
  import nsc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [SEED_INDEX_W-1:0] seed_index;
  logic [POS_W-1:0]        pos_x;
  logic [POS_W-1:0]        pos_y;
  logic [LABEL_W-1:0]      seed_label;

  modport source (output valid, mode, seed_index, pos_x, pos_y, seed_label, input ready);
  modport sink   (input valid, mode, seed_index, pos_x, pos_y, seed_label, output ready);
endinterface : nsc_item_if

`default_nettype wire

@@ rtl/nsc_result_if.sv @@
// Result channel interface: nearest seed label, index and squared distance.
`default_nettype none

interface nsc_result_if
  import nsc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [LABEL_W-1:0]      nearest_label;
  logic [SEED_INDEX_W-1:0] nearest_index;
  logic [DIST_W-1:0]       nearest_dist_sq;

  modport source (output valid, nearest_label, nearest_index, nearest_dist_sq, input ready);
  modport sink   (input valid, nearest_label, nearest_index, nearest_dist_sq, output ready);
endinterface : nsc_result_if

`default_nettype wire

@@ rtl/nsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nsc_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : nsc_ram

`default_nettype wire

@@ rtl/nsc_ctrl.sv @@
// Controller: handshakes, seed count register, scan sequencing and result valid.
`default_nettype none

module nsc_ctrl
  import nsc_pkg::*;
#(
  parameter int MAX_SEEDS = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic [MODE_W-1:0]    in_mode_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [COUNT_W-1:0]   cfg_wdata_i,
  input  wire logic                 pipe_busy_i,
  output nsc_cmd_t                  cmd_o,
  output logic [(MAX_SEEDS > 1 ? $clog2(MAX_SEEDS) : 1)-1:0] issue_addr_o
);

  localparam int IdxW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CntW = $clog2(MAX_SEEDS + 1);
  localparam int CmpW = (COUNT_W > CntW) ? COUNT_W : CntW;

  nsc_state_e         state_q, state_d;
  logic [COUNT_W-1:0] seed_count_q;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [CmpW-1:0]    count_ext;
  logic [CmpW-1:0]    n_ext;
  logic [CntW-1:0]    n;
  logic [CntW-1:0]    cnt_inc;
  logic               in_fire;
  logic               out_free;

  // Clamp the programmed count into 1 .. MAX_SEEDS.
  always_comb begin
    count_ext = CmpW'(seed_count_q);
    if (count_ext == '0) begin
      n_ext = CmpW'(1);
    end else if (count_ext > CmpW'(MAX_SEEDS)) begin
      n_ext = CmpW'(MAX_SEEDS);
    end else begin
      n_ext = count_ext;
    end
  end

  assign n        = n_ext[CntW-1:0];
  assign cnt_inc  = cnt_q + CntW'(1);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seed_count_q <= COUNT_W'(1);
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_count_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i == MODE_QUERY) begin
            cmd_o.start = 1'b1;
            cnt_d       = '0;
            state_d     = ST_SCAN;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        cnt_d       = cnt_inc;
        if (cnt_inc == n) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Hold the best until the pipeline is empty and the result slot frees up.
        if (!pipe_busy_i && out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign issue_addr_o = cnt_q[IdxW-1:0];
  assign out_valid_o  = out_valid_q;

`ifndef SYNTHESIS
  a_load_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !pipe_busy_i)
    else $error("result loaded while distance pipeline still busy");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !pipe_busy_i)
    else $error("transaction accepted while a scan is in flight");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> (cnt_q < n))
    else $error("table read issued beyond the active seed count");

  a_valid_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DRAIN))
    else $error("result valid raised outside the drain step");
`endif

endmodule : nsc_ctrl

`default_nettype wire

@@ rtl/nsc_dp.sv @@
// Datapath: seed table, distance pipeline, running minimum and result register.
`default_nettype none

module nsc_dp
  import nsc_pkg::*;
#(
  parameter int MAX_SEEDS  = 64,
  parameter int COORD_BITS = 10
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire nsc_cmd_t                cmd_i,
  input  wire logic [(MAX_SEEDS > 1 ? $clog2(MAX_SEEDS) : 1)-1:0] issue_addr_i,
  input  wire logic [SEED_INDEX_W-1:0] seed_index_i,
  input  wire logic [POS_W-1:0]        pos_x_i,
  input  wire logic [POS_W-1:0]        pos_y_i,
  input  wire logic [LABEL_W-1:0]      seed_label_i,
  output logic                         pipe_busy_o,
  output logic [LABEL_W-1:0]           nearest_label_o,
  output logic [SEED_INDEX_W-1:0]      nearest_index_o,
  output logic [DIST_W-1:0]            nearest_dist_sq_o
);

  localparam int IdxW   = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CntW   = $clog2(MAX_SEEDS + 1);
  localparam int RangeW = (SEED_INDEX_W > CntW) ? SEED_INDEX_W : CntW;
  localparam int WordW  = 2 * COORD_BITS + LABEL_W;
  localparam int SqW    = 2 * COORD_BITS;
  localparam int SumW   = SqW + 1;
  localparam int SatW   = (SumW > DIST_W) ? SumW : DIST_W;

  logic [COORD_EXT_W-1:0] pos_x_ext, pos_y_ext;
  logic [COORD_BITS-1:0]  px, py;
  logic [RangeW-1:0]      widx;
  logic                   wr_ok;
  logic [WordW-1:0]       wdata, rdata;

  logic [COORD_BITS-1:0]  qx_q, qy_q;
  logic                   v1_q, v2_q, first_q;
  logic [IdxW-1:0]        idx1_q, idx2_q, best_i_q;
  logic [LABEL_W-1:0]     lab2_q, best_lab_q;
  logic [SqW-1:0]         sqx_q, sqy_q;
  logic [SumW-1:0]        best_d_q;

  logic [COORD_BITS-1:0]  rx, ry, dx, dy;
  logic [LABEL_W-1:0]     rlab;
  logic [SumW-1:0]        sum;
  logic                   take;

  logic [RangeW-1:0]      best_i_ext;
  logic [SatW-1:0]        best_d_ext;
  logic [LABEL_W-1:0]     res_label_q;
  logic [SEED_INDEX_W-1:0] res_index_q;
  logic [DIST_W-1:0]      res_dist_q;

  // Mask or extend the coordinates to the configured width.
  assign pos_x_ext = COORD_EXT_W'(pos_x_i);
  assign pos_y_ext = COORD_EXT_W'(pos_y_i);
  assign px        = pos_x_ext[COORD_BITS-1:0];
  assign py        = pos_y_ext[COORD_BITS-1:0];

  // Drop writes aimed past the end of the table.
  assign widx  = RangeW'(seed_index_i);
  assign wr_ok = cmd_i.wr_en && (widx < RangeW'(MAX_SEEDS));
  assign wdata = {seed_label_i, py, px};

  nsc_ram #(
    .WIDTH (WordW),
    .DEPTH (MAX_SEEDS)
  ) u_seed_ram (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (widx[IdxW-1:0]),
    .wdata_i (wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (issue_addr_i),
    .rdata_o (rdata)
  );

  assign rx   = rdata[COORD_BITS-1:0];
  assign ry   = rdata[2*COORD_BITS-1:COORD_BITS];
  assign rlab = rdata[WordW-1:2*COORD_BITS];
  assign dx   = (rx > qx_q) ? (rx - qx_q) : (qx_q - rx);
  assign dy   = (ry > qy_q) ? (ry - qy_q) : (qy_q - ry);

  assign sum  = SumW'(sqx_q) + SumW'(sqy_q);
  // Strict compare: on a tie the earlier (lower) index stays.
  assign take = v2_q && (first_q || (sum < best_d_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      first_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.start) begin
        first_q <= 1'b1;
      end else if (take) begin
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      qx_q <= px;
      qy_q <= py;
    end
    idx1_q <= issue_addr_i;
    idx2_q <= idx1_q;
    lab2_q <= rlab;
    sqx_q  <= SqW'(dx) * SqW'(dx);
    sqy_q  <= SqW'(dy) * SqW'(dy);
    if (take) begin
      best_d_q   <= sum;
      best_i_q   <= idx2_q;
      best_lab_q <= lab2_q;
    end
    if (cmd_i.load_out) begin
      res_label_q <= best_lab_q;
      res_index_q <= best_i_ext[SEED_INDEX_W-1:0];
      res_dist_q  <= (best_d_ext > SatW'(DIST_MAX)) ? DIST_MAX : best_d_ext[DIST_W-1:0];
    end
  end

  assign best_i_ext = RangeW'(best_i_q);
  assign best_d_ext = SatW'(best_d_q);

  assign pipe_busy_o       = v1_q || v2_q;
  assign nearest_label_o   = res_label_q;
  assign nearest_index_o   = res_index_q;
  assign nearest_dist_sq_o = res_dist_q;

endmodule : nsc_dp

`default_nettype wire

@@ rtl/nearest_seed_classifier_core.sv @@
// Top level of the nearest seed classifier: controller plus datapath.
// Queries: a query scans n table entries, n being seed_count clamped into
//   1..MAX_SEEDS; a new query is taken only after the last result is loaded.
// Flow: the single table read port feeds one distance unit one seed per cycle;
//   writes go one per cycle while no query is in flight.
// Reset: asynchronous, active low; clears control state and sets seed_count to
//   1. The seed table is not cleared: scan only entries that have been written.
`default_nettype none

module nearest_seed_classifier_core
  import nsc_pkg::*;
#(
  parameter int MAX_SEEDS  = 64,
  parameter int COORD_BITS = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  nsc_item_if.sink                item_i,
  nsc_result_if.source            result_o,
  input  wire logic               cfg_we_i,
  input  wire logic [COUNT_W-1:0] cfg_wdata_i
);

  localparam int IdxW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;

  // Command and status between the controller and the datapath.
  nsc_cmd_t        cmd;
  logic [IdxW-1:0] issue_addr;
  logic            pipe_busy;

  // The controller owns both handshakes: it takes a transaction only between
  // scans, walks the table one entry per cycle, then waits for the pipeline
  // to drain and for the result register to be free before loading it. A
  // waiting result does not block the next transaction.
  nsc_ctrl #(
    .MAX_SEEDS (MAX_SEEDS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (item_i.valid),
    .in_mode_i    (item_i.mode),
    .in_ready_o   (item_i.ready),
    .out_valid_o  (result_o.valid),
    .out_ready_i  (result_o.ready),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pipe_busy_i  (pipe_busy),
    .cmd_o        (cmd),
    .issue_addr_o (issue_addr)
  );

  // The datapath holds the seed table RAM, a three-step distance pipeline
  // (read, square, add and compare) and the result register.
  nsc_dp #(
    .MAX_SEEDS  (MAX_SEEDS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .issue_addr_i      (issue_addr),
    .seed_index_i      (item_i.seed_index),
    .pos_x_i           (item_i.pos_x),
    .pos_y_i           (item_i.pos_y),
    .seed_label_i      (item_i.seed_label),
    .pipe_busy_o       (pipe_busy),
    .nearest_label_o   (result_o.nearest_label),
    .nearest_index_o   (result_o.nearest_index),
    .nearest_dist_sq_o (result_o.nearest_dist_sq)
  );

endmodule : nearest_seed_classifier_core

`default_nettype wire
